// ===== sv/sorted_multiset_table_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted multiset table assertion macros
// Shared property wrappers for the checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_MULTISET_TABLE_DEFINES_SVH
`define SORTED_MULTISET_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/smt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted multiset table package
// Sizes, codes and shared types of the sorted key/count table.
// ----------------------------------------------------------------------------
`default_nettype none

package smt_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int COUNT_WIDTH = 16;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ENTRY_W = KEY_WIDTH + COUNT_WIDTH;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_COUNT  = 2'd1,
    OP_GET    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_GET_WAIT
  } state_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] cnt;
    logic [KEY_WIDTH-1:0]   key;
  } entry_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

`default_nettype wire

// ===== sv/smt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/smt_cmp.sv =====
// ----------------------------------------------------------------------------
// Key compare unit
// Equality and signed or unsigned greater-than of a stored key against a key.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_cmp import smt_pkg::*; (
  input  wire logic [KEY_WIDTH-1:0] stored_key,
  input  wire logic [KEY_WIDTH-1:0] probe_key,
  input  wire logic                 key_signed,
  output cmp_res_t                  res
);

  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] a_ord;
  logic [KEY_WIDTH-1:0] b_ord;

  // bias the sign bit so signed order becomes unsigned order
  assign flip  = {key_signed, {(KEY_WIDTH-1){1'b0}}};
  assign a_ord = stored_key ^ flip;
  assign b_ord = probe_key ^ flip;

  assign res.eq = (stored_key == probe_key);
  assign res.gt = (a_ord > b_ord);

endmodule

`default_nettype wire

// ===== sv/sorted_multiset_table.sv =====
// ----------------------------------------------------------------------------
// Sorted multiset table
// Count and insert scan the N entries in use, one compare each. Insert then
// raises the count of a key present, or shifts the entries from position p
// upward and writes a new key at p. Get reads the entry at a position; an
// out-of-range one needs no RAM read. One item at a time, paced by the single
// RAM read port and compare unit. Synchronous active-low reset empties the
// table and clears key order to unsigned; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_multiset_table_defines.svh"

module sorted_multiset_table import smt_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_wdata,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_opcode,
  input  wire logic [KEY_WIDTH-1:0]   in_key,
  input  wire logic [IDX_W-1:0]       in_position,
  output logic                        out_valid,
  output logic [IDX_W-1:0]            out_result_position,
  output logic [COUNT_WIDTH-1:0]      out_result_count,
  output logic [KEY_WIDTH-1:0]        out_result_key,
  output logic [1:0]                  out_status
);

  state_t state_r, state_nxt;

  logic                   key_signed_r;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]       issue_r, issue_nxt;
  logic                   rvld_r, rvld_nxt;
  logic [IDX_W-1:0]       ridx_r, ridx_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       match_idx_r, match_idx_nxt;
  logic [COUNT_WIDTH-1:0] match_cnt_r, match_cnt_nxt;
  logic                   gt_found_r, gt_found_nxt;
  logic [CNT_W-1:0]       gt_idx_r, gt_idx_nxt;
  logic [CNT_W-1:0]       ins_idx_r, ins_idx_nxt;
  logic [CNT_W-1:0]       sh_idx_r, sh_idx_nxt;

  logic                   ov_r, ov_nxt;
  logic [IDX_W-1:0]       opos_r, opos_nxt;
  logic [COUNT_WIDTH-1:0] ocnt_r, ocnt_nxt;
  logic [KEY_WIDTH-1:0]   okey_r, okey_nxt;
  logic [1:0]             ost_r, ost_nxt;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  entry_t                 ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  entry_t                 rd_entry;
  cmp_res_t               cmp;
  logic                   accept;
  logic                   issuing;
  logic [COUNT_WIDTH-1:0] inc_cnt;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign rd_entry = entry_t'(ram_rdata);
  assign inc_cnt  = (match_cnt_r == {COUNT_WIDTH{1'b1}}) ? match_cnt_r
                                                        : match_cnt_r + 1'b1;
  assign issuing  = (state_r == S_SCAN)  ? (issue_r < total_r) :
                    (state_r == S_SHIFT) ? (sh_idx_r > ins_idx_r) : 1'b0;

  smt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smt_cmp u_cmp (
    .stored_key (rd_entry.key),
    .probe_key  (key_r),
    .key_signed (key_signed_r),
    .res        (cmp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_INSERT, OP_COUNT: state_nxt = S_SCAN;
            OP_GET: begin
              if ({1'b0, in_position} < total_r) state_nxt = S_GET_WAIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (!issuing) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (op_r == OP_INSERT && !found_r && total_r < CNT_W'(DEPTH)) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (!issuing && !rvld_r) state_nxt = S_PLACE;
      end
      S_PLACE:    state_nxt = S_IDLE;
      S_GET_WAIT: state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    total_nxt     = total_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    issue_nxt     = issue_r;
    rvld_nxt      = 1'b0;
    ridx_nxt      = ridx_r;
    found_nxt     = found_r;
    match_idx_nxt = match_idx_r;
    match_cnt_nxt = match_cnt_r;
    gt_found_nxt  = gt_found_r;
    gt_idx_nxt    = gt_idx_r;
    ins_idx_nxt   = ins_idx_r;
    sh_idx_nxt    = sh_idx_r;
    ov_nxt        = 1'b0;
    opos_nxt      = '0;
    ocnt_nxt      = '0;
    okey_nxt      = '0;
    ost_nxt       = ST_OK;
    ram_we        = 1'b0;
    ram_waddr     = ridx_r + 1'b1;
    ram_wdata     = rd_entry;
    ram_raddr     = in_position;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt       = in_opcode;
          key_nxt      = in_key;
          issue_nxt    = '0;
          found_nxt    = 1'b0;
          gt_found_nxt = 1'b0;
          if (in_opcode == OP_GET && {1'b0, in_position} >= total_r) begin
            ov_nxt  = 1'b1;
            ost_nxt = ST_RANGE;
          end
        end
      end
      S_SCAN: begin
        ram_raddr = issue_r[IDX_W-1:0];
        if (issuing) begin
          rvld_nxt  = 1'b1;
          ridx_nxt  = issue_r[IDX_W-1:0];
          issue_nxt = issue_r + 1'b1;
        end
        if (rvld_r) begin
          if (cmp.eq && !found_r) begin
            found_nxt     = 1'b1;
            match_idx_nxt = ridx_r;
            match_cnt_nxt = rd_entry.cnt;
          end
          if (cmp.gt && !gt_found_r) begin
            gt_found_nxt = 1'b1;
            gt_idx_nxt   = {1'b0, ridx_r};
          end
        end
      end
      S_DECIDE: begin
        ins_idx_nxt = gt_found_r ? gt_idx_r : total_r;
        sh_idx_nxt  = total_r;
        if (op_r == OP_INSERT) begin
          if (found_r) begin
            ram_we        = 1'b1;
            ram_waddr     = match_idx_r;
            ram_wdata.key = key_r;
            ram_wdata.cnt = inc_cnt;
            ov_nxt        = 1'b1;
            opos_nxt      = match_idx_r;
            ocnt_nxt      = inc_cnt;
          end else if (total_r >= CNT_W'(DEPTH)) begin
            ov_nxt  = 1'b1;
            ost_nxt = ST_FULL;
          end
        end else begin
          ov_nxt = 1'b1;
          if (found_r) begin
            opos_nxt = match_idx_r;
            ocnt_nxt = match_cnt_r;
          end
        end
      end
      S_SHIFT: begin
        ram_raddr = IDX_W'(sh_idx_r - 1'b1);
        if (issuing) begin
          rvld_nxt   = 1'b1;
          ridx_nxt   = IDX_W'(sh_idx_r - 1'b1);
          sh_idx_nxt = sh_idx_r - 1'b1;
        end
        if (rvld_r) begin
          ram_we = 1'b1;
        end
      end
      S_PLACE: begin
        ram_we        = 1'b1;
        ram_waddr     = ins_idx_r[IDX_W-1:0];
        ram_wdata.key = key_r;
        ram_wdata.cnt = COUNT_WIDTH'(1);
        total_nxt     = total_r + 1'b1;
        ov_nxt        = 1'b1;
        opos_nxt      = ins_idx_r[IDX_W-1:0];
        ocnt_nxt      = COUNT_WIDTH'(1);
      end
      S_GET_WAIT: begin
        ov_nxt   = 1'b1;
        opos_nxt = ridx_r;
        ocnt_nxt = rd_entry.cnt;
        okey_nxt = rd_entry.key;
      end
      default: begin
        ov_nxt = 1'b0;
      end
    endcase
    // capture the get position for the read in flight
    if (state_r == S_IDLE) ridx_nxt = in_position;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      key_signed_r <= 1'b0;
      rvld_r       <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      rvld_r  <= rvld_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) key_signed_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    issue_r     <= issue_nxt;
    ridx_r      <= ridx_nxt;
    found_r     <= found_nxt;
    match_idx_r <= match_idx_nxt;
    match_cnt_r <= match_cnt_nxt;
    gt_found_r  <= gt_found_nxt;
    gt_idx_r    <= gt_idx_nxt;
    ins_idx_r   <= ins_idx_nxt;
    sh_idx_r    <= sh_idx_nxt;
    opos_r      <= opos_nxt;
    ocnt_r      <= ocnt_nxt;
    okey_r      <= okey_nxt;
    ost_r       <= ost_nxt;
  end

  assign out_valid           = ov_r;
  assign out_result_position = opos_r;
  assign out_result_count    = ocnt_r;
  assign out_result_key      = okey_r;
  assign out_status          = ost_r;

  `SMT_ASSERT_NOW(a_strobe_idle, out_valid, state_r == S_IDLE, "result while busy")
  `SMT_ASSERT_NOW(a_total_max, 1'b1, total_r <= CNT_W'(DEPTH), "entry total overflow")
  `SMT_ASSERT_NOW(a_shift_room, state_r == S_SHIFT, total_r < CNT_W'(DEPTH), "shift when full")
  `SMT_ASSERT_NOW(a_full_flag, out_valid && out_status == ST_FULL, total_r == CNT_W'(DEPTH), "full")
  `SMT_ASSERT_NEXT(a_place_grow, state_r == S_PLACE, total_r == $past(total_r) + 1'b1, "no growth")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Sorted multiset table testbench
// Drives insert, count and get items through the start/busy handshake and
// checks each strobed result against a shadow copy of the key/count table
// that is kept alongside the block. A directed part covers the empty table,
// key extremes, repeated keys, out-of-range gets and a change of key
// order with entries stored. A random part follows in phases that switch the
// key order, with random start gaps except in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  import smt_pkg::*;

  localparam logic [1:0]             OP_UNUSED    = 2'd3;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;
  localparam int unsigned            CYCLE_LIMIT  = 2_000_000;
  localparam int                     SETTLE       = 48;
  localparam int                     PHASES       = 6;
  localparam int                     PHASE_ITEMS  = 150;

  typedef struct packed {
    status_t                status;
    logic [IDX_W-1:0]       position;
    logic [COUNT_WIDTH-1:0] count;
    logic [KEY_WIDTH-1:0]   key;
  } table_reply_t;

  class multiset_predictor;
    logic [KEY_WIDTH-1:0]   keys [DEPTH];
    logic [COUNT_WIDTH-1:0] counts [DEPTH];
    int                     used;
    bit                     signed_order;
    table_reply_t           replies_due [$];
    int                     errors;

    function new();
      used = 0;
      signed_order = 1'b0;
      errors = 0;
    endfunction

    function int find_key(logic [KEY_WIDTH-1:0] k);
      for (int i = 0; i < used; i++) begin
        if (keys[i] == k) return i;
      end
      return used;
    endfunction

    function bit orders_above(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
      if (signed_order) return $signed(a) > $signed(b);
      return a > b;
    endfunction

    function void apply_item(logic [1:0] op, logic [KEY_WIDTH-1:0] k,
                             logic [IDX_W-1:0] p);
      table_reply_t r;
      int idx;
      if (op == OP_UNUSED) return;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          idx = find_key(k);
          if (idx < used) begin
            if (counts[idx] != COUNT_MAX) counts[idx]++;
            r.position = IDX_W'(idx);
            r.count = counts[idx];
          end else if (used >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            idx = used;
            for (int j = 0; j < used; j++) begin
              if (orders_above(keys[j], k)) begin
                idx = j;
                break;
              end
            end
            for (int j = used; j > idx; j--) begin
              keys[j] = keys[j-1];
              counts[j] = counts[j-1];
            end
            keys[idx] = k;
            counts[idx] = COUNT_WIDTH'(1);
            used++;
            r.position = IDX_W'(idx);
            r.count = COUNT_WIDTH'(1);
          end
        end
        OP_COUNT: begin
          idx = find_key(k);
          if (idx < used) begin
            r.position = IDX_W'(idx);
            r.count = counts[idx];
          end
        end
        default: begin
          if (int'(p) < used) begin
            r.position = p;
            r.count = counts[p];
            r.key = keys[p];
          end else begin
            r.status = ST_RANGE;
          end
        end
      endcase
      replies_due.push_back(r);
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
    endtask

    task compare_reply(table_reply_t got);
      table_reply_t want;
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected result", 64'(got), '0);
        return;
      end
      want = replies_due.pop_front();
      if (got.position !== want.position)
        report_mismatch("result_position", 64'(got.position), 64'(want.position));
      if (got.count !== want.count)
        report_mismatch("result_count", 64'(got.count), 64'(want.count));
      if (got.key !== want.key)
        report_mismatch("result_key", 64'(got.key), 64'(want.key));
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic                   cfg_wdata = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             in_opcode = OP_INSERT;
  logic [KEY_WIDTH-1:0]   in_key = '0;
  logic [IDX_W-1:0]       in_position = '0;
  logic                   out_valid;
  logic [IDX_W-1:0]       out_result_position;
  logic [COUNT_WIDTH-1:0] out_result_count;
  logic [KEY_WIDTH-1:0]   out_result_key;
  logic [1:0]             out_status;

  int unsigned            cycle_count = 0;
  multiset_predictor      shadow = new();

  sorted_multiset_table DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_key              (in_key),
    .in_position         (in_position),
    .out_valid           (out_valid),
    .out_result_position (out_result_position),
    .out_result_count    (out_result_count),
    .out_result_key      (out_result_key),
    .out_status          (out_status)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin : result_watch
    table_reply_t got;
    if (rst_n && out_valid) begin
      got.status = status_t'(out_status);
      got.position = out_result_position;
      got.count = out_result_count;
      got.key = out_result_key;
      shadow.compare_reply(got);
    end
  end

  // hold the item until an edge with busy low takes it
  task automatic send_item(logic [1:0] op, logic [KEY_WIDTH-1:0] k,
                           logic [IDX_W-1:0] p);
    in_opcode <= op;
    in_key <= k;
    in_position <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.apply_item(op, k, p);
  endtask

  task automatic idle_burst(bit enable);
    if (enable && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // drop start and wait out every pending result plus any trailing work
  task automatic quiesce();
    start <= 1'b0;
    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_order(bit signed_keys);
    quiesce();
    cfg_we <= 1'b1;
    cfg_wdata <= signed_keys;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.signed_order = signed_keys;
  endtask

  function automatic logic [KEY_WIDTH-1:0] any_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(KEY_WIDTH-1){1'b0}}};
      3:       return {1'b0, {(KEY_WIDTH-1){1'b1}}};
      4:       return KEY_WIDTH'($urandom_range(0, 15));
      5:       return ~KEY_WIDTH'($urandom_range(0, 15));
      default: return KEY_WIDTH'($urandom);
    endcase
  endfunction

  task automatic random_item();
    int unsigned          roll;
    logic [1:0]           op;
    logic [KEY_WIDTH-1:0] k;
    logic [IDX_W-1:0]     p;
    bit                   fresh;
    roll = $urandom_range(0, 99);
    p = IDX_W'($urandom_range(0, DEPTH-1));
    if (roll < 40) begin
      op = OP_INSERT;
      fresh = (shadow.used == 0) ||
              ($urandom_range(0, (shadow.used < DEPTH) ? 15 : 2) == 0);
    end else if (roll < 70) begin
      op = OP_COUNT;
      fresh = (shadow.used == 0) || ($urandom_range(0, 9) < 3);
    end else if (roll < 95) begin
      op = OP_GET;
      fresh = 1'b1;
    end else begin
      op = OP_UNUSED;
      fresh = 1'b1;
    end
    k = fresh ? any_key() : shadow.keys[$urandom_range(0, shadow.used - 1)];
    send_item(op, k, p);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OP_GET, 32'h0000_0000, 4'd0);
    send_item(OP_COUNT, 32'h0000_0000, 4'd0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 4'd15);

    // bump one count while the table holds a single entry
    for (int n = 0; n < 4; n++)
      send_item(OP_INSERT, 32'h8000_0000, 4'd0);

    send_item(OP_INSERT, 32'hFFFF_FFFF, 4'd0);
    send_item(OP_INSERT, 32'h0000_0000, 4'd15);
    send_item(OP_INSERT, 32'h7FFF_FFFF, 4'd0);
    send_item(OP_INSERT, 32'h0000_0000, 4'd0);
    send_item(OP_COUNT, 32'hFFFF_FFFF, 4'd0);
    send_item(OP_COUNT, 32'h1234_5678, 4'd0);
    send_item(OP_GET, 32'h0000_0000, 4'd0);
    send_item(OP_GET, 32'h0000_0000, 4'd3);
    send_item(OP_GET, 32'h0000_0000, 4'd4);
    send_item(OP_GET, 32'hFFFF_FFFF, 4'd15);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 4'd0);

    write_order(1'b1);
    send_item(OP_INSERT, 32'hFFFF_FFFE, 4'd0);
    send_item(OP_INSERT, 32'h0000_0001, 4'd0);
    send_item(OP_COUNT, 32'h8000_0000, 4'd0);
    send_item(OP_COUNT, 32'h0000_0000, 4'd0);
    send_item(OP_GET, 32'h0000_0000, 4'd0);
    send_item(OP_GET, 32'h0000_0000, 4'd2);
    send_item(OP_GET, 32'h0000_0000, 4'd5);
    send_item(OP_GET, 32'h0000_0000, 4'd6);
    write_order(1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        idle_burst(ph != PHASES - 1);
        random_item();
        if (ph == 2 && n == 60) quiesce();
      end
      if (ph != PHASES - 1) write_order(ph % 2 == 0);
    end

    quiesce();
    if (shadow.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
